>>> hdl/lcps_pkg.sv
// Shared constants and register map for the LED chain pixel serializer.
package lcps_pkg;

    localparam int CHANNEL_BITS         = 8;
    localparam int PIXEL_BITS           = 3 * CHANNEL_BITS;
    localparam int PRODUCT_BITS         = 3 * CHANNEL_BITS;
    localparam int BITS_LEFT_W          = $clog2(PIXEL_BITS + 1);
    localparam int SCALE_STEPS          = 2 * CHANNEL_BITS;
    localparam int STEP_W               = $clog2(SCALE_STEPS);
    localparam int COUNTER_BITS_DEFAULT = 16;
    localparam int CFG_DATA_BITS        = 16;
    localparam int CFG_INDEX_BITS       = 3;
    localparam int NUM_LANES            = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_INTERVAL   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ONE_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_HIGH  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LATE_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_GAIN = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RED_GAIN   = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_GAIN  = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BRIGHTNESS = 3'd7;

    // Reset values of the registers
    localparam logic [15:0] RST_INTERVAL   = 16'd1200;
    localparam logic [15:0] RST_ONE_HIGH   = 16'd900;
    localparam logic [15:0] RST_ZERO_HIGH  = 16'd300;
    localparam logic [15:0] RST_LATE_LIMIT = 16'd49000;
    localparam logic [CHANNEL_BITS-1:0] RST_GAIN       = 8'd255;
    localparam logic [CHANNEL_BITS-1:0] RST_BRIGHTNESS = 8'd255;

    // Word kinds on the input channel
    localparam logic ACTION_TICK  = 1'b0;
    localparam logic ACTION_PIXEL = 1'b1;

endpackage

>>> hdl/led_chain_pixel_serializer_core.sv
// Top level of the LED chain pixel serializer: pulse timing, frame control, serial scaling.
//
// Single-wire pulse-width serializer for chained RGB pixels. Each input word is either a
// tick (one bit-clock step: the word's result carries the line level for that step) or a
// pixel offer. Each word produces exactly one result word. A steady tick stream runs at
// one word per cycle while the result side keeps up; the result register lets the next
// word in while the previous result is being taken. An accepted pixel offer is answered
// at once, then the color-correction unit scales green, red and blue in three parallel
// shift-add lanes, one multiplier bit per cycle: first value*gain, then the product times
// brightness. A pixel offer that is taken into the holding slot holds off further words
// until both multiplications are done; offers that are ignored, dropped or that abort a
// frame do not. Configuration writes are registered and are meant for idle periods only.
// COUNTER_BITS sets the width of the bit-period, high-time and idle-gap counters; register
// values are cut or zero-extended to it.
module led_chain_pixel_serializer_core #(
    parameter int COUNTER_BITS = lcps_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // configuration write port
    input  logic                                  cfg_write,
    input  logic [lcps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [lcps_pkg::CFG_DATA_BITS-1:0]    cfg_data,

    // input words
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  action,
    input  logic [lcps_pkg::CHANNEL_BITS-1:0]     green,
    input  logic [lcps_pkg::CHANNEL_BITS-1:0]     red,
    input  logic [lcps_pkg::CHANNEL_BITS-1:0]     blue,
    input  logic                                  last_pixel,

    // result words
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  line_level,
    output logic                                  slot_free,
    output logic                                  frame_done,
    output logic                                  frame_aborted
);

    localparam int CW    = COUNTER_BITS;
    localparam int CHB   = lcps_pkg::CHANNEL_BITS;
    localparam int PXB   = lcps_pkg::PIXEL_BITS;
    localparam int PRB   = lcps_pkg::PRODUCT_BITS;
    localparam int BLW   = lcps_pkg::BITS_LEFT_W;
    localparam int SW    = lcps_pkg::STEP_W;
    localparam int LANES = lcps_pkg::NUM_LANES;
    localparam logic [SW-1:0] STEP_MID  = SW'(CHB - 1);
    localparam logic [SW-1:0] STEP_LAST = SW'(lcps_pkg::SCALE_STEPS - 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCALE
    } state_t;

    // configuration registers
    logic [15:0]     interval_reg, one_high_reg, zero_high_reg, late_limit_reg;
    logic [CHB-1:0]  green_gain_reg, red_gain_reg, blue_gain_reg, brightness_reg;

    // frame and pulse state
    state_t          state_reg, state_next;
    logic [PXB-1:0]  held_pixel_reg, held_pixel_next;
    logic            held_full_reg, held_full_next;
    logic            held_last_reg, held_last_next;
    logic [PXB-1:0]  shift_bits_reg, shift_bits_next;
    logic [BLW-1:0]  bits_left_reg, bits_left_next;
    logic [CW-1:0]   period_count_reg, period_count_next;
    logic [CW-1:0]   high_time_reg, high_time_next;
    logic [CW-1:0]   gap_count_reg, gap_count_next;
    logic            frame_active_reg, frame_active_next;
    logic            dropping_reg, dropping_next;

    // result register
    logic            out_valid_reg, out_valid_next;
    logic            level_reg, level_next;
    logic            slot_free_reg, slot_free_next;
    logic            done_reg, done_next;
    logic            aborted_reg, aborted_next;

    // scaling lanes: green, red, blue
    logic [PRB-1:0]  acc_reg    [LANES];
    logic [PRB-1:0]  acc_next   [LANES];
    logic [PRB-1:0]  mcand_reg  [LANES];
    logic [PRB-1:0]  mcand_next [LANES];
    logic [CHB-1:0]  mplier_reg [LANES];
    logic [CHB-1:0]  mplier_next[LANES];
    logic [SW-1:0]   step_reg, step_next;

    logic            take_word;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign take_word = in_valid && in_ready;

    // Configuration writes: no handshake, take data at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg   <= lcps_pkg::RST_INTERVAL;
            one_high_reg   <= lcps_pkg::RST_ONE_HIGH;
            zero_high_reg  <= lcps_pkg::RST_ZERO_HIGH;
            late_limit_reg <= lcps_pkg::RST_LATE_LIMIT;
            green_gain_reg <= lcps_pkg::RST_GAIN;
            red_gain_reg   <= lcps_pkg::RST_GAIN;
            blue_gain_reg  <= lcps_pkg::RST_GAIN;
            brightness_reg <= lcps_pkg::RST_BRIGHTNESS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lcps_pkg::REG_INTERVAL:   interval_reg   <= cfg_data;
                lcps_pkg::REG_ONE_HIGH:   one_high_reg   <= cfg_data;
                lcps_pkg::REG_ZERO_HIGH:  zero_high_reg  <= cfg_data;
                lcps_pkg::REG_LATE_LIMIT: late_limit_reg <= cfg_data;
                lcps_pkg::REG_GREEN_GAIN: green_gain_reg <= cfg_data[CHB-1:0];
                lcps_pkg::REG_RED_GAIN:   red_gain_reg   <= cfg_data[CHB-1:0];
                lcps_pkg::REG_BLUE_GAIN:  blue_gain_reg  <= cfg_data[CHB-1:0];
                lcps_pkg::REG_BRIGHTNESS: brightness_reg <= cfg_data[CHB-1:0];
                default: ;
            endcase
        end
    end

    // Word handling and pulse timing.
    always_comb
    begin
        logic [CW-1:0] iv_raw;
        logic [CW-1:0] iv;
        logic [CW-1:0] hi;
        logic [CW-1:0] late_lim;
        logic [CW-1:0] gap_max;

        iv_raw   = CW'(interval_reg);
        iv       = (iv_raw == '0) ? CW'(1) : iv_raw;
        late_lim = CW'(late_limit_reg);
        gap_max  = '1;
        hi       = '0;

        state_next        = state_reg;
        held_pixel_next   = held_pixel_reg;
        held_full_next    = held_full_reg;
        held_last_next    = held_last_reg;
        shift_bits_next   = shift_bits_reg;
        bits_left_next    = bits_left_reg;
        period_count_next = period_count_reg;
        high_time_next    = high_time_reg;
        gap_count_next    = gap_count_reg;
        frame_active_next = frame_active_reg;
        dropping_next     = dropping_reg;

        out_valid_next = out_valid_reg && !out_ready;
        level_next     = level_reg;
        slot_free_next = slot_free_reg;
        done_next      = done_reg;
        aborted_next   = aborted_reg;

        for (int i = 0; i < LANES; i++)
        begin
            acc_next[i]    = acc_reg[i];
            mcand_next[i]  = mcand_reg[i];
            mplier_next[i] = mplier_reg[i];
        end
        step_next = step_reg;

        if (state_reg == ST_SCALE)
        begin
            // One multiplier bit per lane per cycle.
            for (int i = 0; i < LANES; i++)
            begin
                acc_next[i]    = mplier_reg[i][0] ? acc_reg[i] + mcand_reg[i] : acc_reg[i];
                mcand_next[i]  = mcand_reg[i] << 1;
                mplier_next[i] = mplier_reg[i] >> 1;
            end
            step_next = step_reg + SW'(1);
            if (step_reg == STEP_MID)
            begin
                // value*gain is ready: reload to multiply by brightness
                for (int i = 0; i < LANES; i++)
                begin
                    mcand_next[i]  = acc_next[i];
                    acc_next[i]    = '0;
                    mplier_next[i] = brightness_reg;
                end
            end
            if (step_reg == STEP_LAST)
            begin
                held_pixel_next = {acc_next[0][PRB-1 -: CHB],
                                   acc_next[1][PRB-1 -: CHB],
                                   acc_next[2][PRB-1 -: CHB]};
                state_next = ST_IDLE;
            end
        end
        else if (take_word)
        begin
            out_valid_next = 1'b1;
            level_next     = 1'b0;
            done_next      = 1'b0;
            aborted_next   = 1'b0;

            if (action == lcps_pkg::ACTION_PIXEL)
            begin
                if (dropping_reg)
                begin
                    // drop offers up to and including the frame's last one
                    if (last_pixel)
                        dropping_next = 1'b0;
                end
                else if (!held_full_reg && !held_last_reg)
                begin
                    if (frame_active_reg && period_count_reg == '0 &&
                        bits_left_reg == '0 && gap_count_reg > late_lim)
                    begin
                        // late pixel: end the frame with the line low
                        frame_active_next = 1'b0;
                        period_count_next = '0;
                        high_time_next    = '0;
                        gap_count_next    = '0;
                        bits_left_next    = '0;
                        shift_bits_next   = '0;
                        dropping_next     = !last_pixel;
                        aborted_next      = 1'b1;
                    end
                    else
                    begin
                        held_full_next = 1'b1;
                        held_last_next = last_pixel;
                        if (!frame_active_reg)
                        begin
                            // open the frame with one low bit period
                            frame_active_next = 1'b1;
                            period_count_next = iv;
                            high_time_next    = '0;
                            bits_left_next    = '0;
                            gap_count_next    = '0;
                        end
                        acc_next[0]    = '0;
                        acc_next[1]    = '0;
                        acc_next[2]    = '0;
                        mcand_next[0]  = PRB'(green);
                        mcand_next[1]  = PRB'(red);
                        mcand_next[2]  = PRB'(blue);
                        mplier_next[0] = green_gain_reg;
                        mplier_next[1] = red_gain_reg;
                        mplier_next[2] = blue_gain_reg;
                        step_next      = '0;
                        state_next     = ST_SCALE;
                    end
                end
            end
            else if (frame_active_reg)
            begin
                if (period_count_reg == '0)
                begin
                    if (bits_left_reg == '0 && held_full_reg)
                    begin
                        shift_bits_next = held_pixel_reg;
                        bits_left_next  = BLW'(PXB);
                        held_full_next  = 1'b0;
                    end
                    if (bits_left_next != '0)
                    begin
                        hi = shift_bits_next[PXB-1] ? CW'(one_high_reg) : CW'(zero_high_reg);
                        shift_bits_next   = shift_bits_next << 1;
                        bits_left_next    = bits_left_next - BLW'(1);
                        period_count_next = iv;
                        high_time_next    = (hi > iv) ? iv : hi;
                        gap_count_next    = '0;
                    end
                end
                if (period_count_next != '0)
                begin
                    level_next = (high_time_next != '0);
                    if (high_time_next != '0)
                        high_time_next = high_time_next - CW'(1);
                    period_count_next = period_count_next - CW'(1);
                    if (period_count_next == '0 && bits_left_next == '0 && !held_full_next)
                    begin
                        if (held_last_next)
                        begin
                            done_next         = 1'b1;
                            frame_active_next = 1'b0;
                            held_last_next    = 1'b0;
                        end
                        gap_count_next = '0;
                    end
                end
                else if (gap_count_next != gap_max)
                begin
                    // count idle ticks, saturating
                    gap_count_next = gap_count_next + CW'(1);
                end
            end

            slot_free_next = !held_full_next && !held_last_next;
        end
    end

    // State, lanes and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            held_full_reg    <= 1'b0;
            held_last_reg    <= 1'b0;
            shift_bits_reg   <= '0;
            bits_left_reg    <= '0;
            period_count_reg <= '0;
            high_time_reg    <= '0;
            gap_count_reg    <= '0;
            frame_active_reg <= 1'b0;
            dropping_reg     <= 1'b0;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
            level_reg        <= 1'b0;
            slot_free_reg    <= 1'b0;
            done_reg         <= 1'b0;
            aborted_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            held_full_reg    <= held_full_next;
            held_last_reg    <= held_last_next;
            shift_bits_reg   <= shift_bits_next;
            bits_left_reg    <= bits_left_next;
            period_count_reg <= period_count_next;
            high_time_reg    <= high_time_next;
            gap_count_reg    <= gap_count_next;
            frame_active_reg <= frame_active_next;
            dropping_reg     <= dropping_next;
            step_reg         <= step_next;
            out_valid_reg    <= out_valid_next;
            level_reg        <= level_next;
            slot_free_reg    <= slot_free_next;
            done_reg         <= done_next;
            aborted_reg      <= aborted_next;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge clk)
    begin
        held_pixel_reg <= held_pixel_next;
        for (int i = 0; i < LANES; i++)
        begin
            acc_reg[i]    <= acc_next[i];
            mcand_reg[i]  <= mcand_next[i];
            mplier_reg[i] <= mplier_next[i];
        end
    end

    assign out_valid     = out_valid_reg;
    assign line_level    = level_reg;
    assign slot_free     = slot_free_reg;
    assign frame_done    = done_reg;
    assign frame_aborted = aborted_reg;

endmodule
